// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the thread slot scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTS_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("scheduler assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define CTS_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("scheduler assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/cts_pkg.sv =====
// Types, codes and default sizes shared by the thread slot scheduler modules.
package cts_pkg;

  // Default table size and thread id width.
  localparam int unsigned NumSlotsDef = 16;
  localparam int unsigned IdBitsDef   = 16;

  // Request kinds.
  typedef enum logic [2:0] {
    FUNC_CREATE  = 3'd0,
    FUNC_YIELD   = 3'd1,
    FUNC_EXIT    = 3'd2,
    FUNC_SUSPEND = 3'd3,
    FUNC_RESUME  = 3'd4
  } func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NORUN   = 2'd2,
    STAT_IGNORED = 2'd3
  } status_e;

  // Per-slot thread state.
  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_RUNNING  = 2'd1,
    SLOT_RUNNABLE = 2'd2,
    SLOT_WAIT     = 2'd3
  } slot_state_e;

  // Controller states.
  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SCAN,
    CTL_APPLY,
    CTL_RESP
  } ctl_state_e;

  // Request transaction payload.
  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] target_tid;
    logic [31:0] entry_address;
  } req_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] new_tid;
    logic        switched;
    logic [3:0]  running_slot;
    logic [15:0] running_tid;
    logic        first_run;
    logic [31:0] start_address;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan;
    logic apply;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/cooperative_thread_slot_scheduler.sv =====
// Top level of the cooperative thread slot scheduler.
//
// Each request (create, yield, exit, suspend, resume) passes through four
// controller states, from its acceptance to the load of its result: one to
// accept, one to register the per-slot free, runnable and id-match flags, one
// to pick the lowest matching slot and update the table, and one to collect
// the registered read of the start address memory into the output register.
// A new request is accepted while the previous result still waits in the
// output register; a result that is still waiting when the next one is
// ready holds the controller in its last state. No clearing pass follows
// reset: the slot states and ids reset in flip-flops, and start addresses are
// only to be read from slots that a create has written; the user must keep to
// this, as the block itself does not enforce it.
`include "assert_macros.svh"

module cooperative_thread_slot_scheduler #(
  parameter int unsigned NumSlots = cts_pkg::NumSlotsDef,
  parameter int unsigned IdBits   = cts_pkg::IdBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cts_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cts_pkg::rsp_t out_rsp_o
);
  import cts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  cts_datapath #(
    .NumSlots(NumSlots),
    .IdBits  (IdBits)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // An accepted transaction is always followed by the flag scan.
  `CTS_ASSERT_NXT(a_scan_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, cmd.scan)
  // The result register is only loaded when it is free.
  `CTS_ASSERT_IMP(a_load_when_free, clk_i, rst_ni, cmd.load, sts.out_free)
  // While ready, no request is in flight in the datapath.
  `CTS_ASSERT_IMP(a_idle_no_work, clk_i, rst_ni, in_ready_o, !(cmd.scan || cmd.apply || cmd.load))
  // A switch is only reported with a successful status.
  `CTS_ASSERT_IMP(a_switch_done, clk_i, rst_ni, out_valid_o && out_rsp_o.switched, out_rsp_o.status == STAT_DONE)

endmodule

// ===== hw/rtl/cts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module cts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cts_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
module cts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cts_pkg::sts_t sts_i,
  output cts_pkg::cmd_t cmd_o
);
  import cts_pkg::*;

  ctl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      CTL_IDLE: begin
        if (in_valid_i) begin
          state_d = CTL_SCAN;
        end
      end
      CTL_SCAN:  state_d = CTL_APPLY;
      CTL_APPLY: state_d = CTL_RESP;
      CTL_RESP: begin
        if (sts_i.out_free) begin
          state_d = CTL_IDLE;
        end
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      CTL_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      CTL_SCAN:  cmd_o.scan  = 1'b1;
      CTL_APPLY: cmd_o.apply = 1'b1;
      CTL_RESP:  cmd_o.load  = sts_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/cts_datapath.sv =====
// Datapath: slot table, scan flags, update logic and the result register.
module cts_datapath #(
  parameter int unsigned NumSlots = cts_pkg::NumSlotsDef,
  parameter int unsigned IdBits   = cts_pkg::IdBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cts_pkg::req_t in_req_i,
  input  cts_pkg::cmd_t cmd_i,
  output cts_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cts_pkg::rsp_t out_rsp_o
);
  import cts_pkg::*;

  localparam int unsigned SlotW = $clog2(NumSlots);
  localparam int unsigned SlotExtW = (SlotW > 4) ? SlotW : 4;
  localparam int unsigned IdExtW = (IdBits > 16) ? IdBits : 16;

  // Slot table and scheduler state.
  slot_state_e         state_q [NumSlots];
  slot_state_e         state_d [NumSlots];
  logic [IdBits-1:0]   id_q    [NumSlots];
  logic [IdBits-1:0]   id_d    [NumSlots];
  logic [NumSlots-1:0] fresh_q, fresh_d;
  logic [SlotW-1:0]    cur_q, cur_d;
  logic [IdBits-1:0]   next_id_q, next_id_d;

  // Captured request and per-request results.
  req_t        req_q, req_d;
  status_e     stat_q, stat_d;
  logic [15:0] new_tid_q, new_tid_d;
  logic        sw_q, sw_d;
  logic        fr_q, fr_d;

  // Scan flag vectors.
  logic [NumSlots-1:0] free_q, free_d;
  logic [NumSlots-1:0] pick_q, pick_d;
  logic [NumSlots-1:0] idm_q, idm_d;

  // Result register.
  logic out_valid_q;
  rsp_t out_q;

  // Start address memory.
  logic             ram_we, ram_re;
  logic [SlotW-1:0] free_idx, pick_idx, idm_idx;
  logic [31:0]      ram_rdata;

  logic [IdExtW-1:0]   next_id_ext;
  logic [SlotExtW-1:0] cur_ext;
  logic [IdExtW-1:0]   cur_id_ext;

  // Lowest set bit of a slot vector.
  function automatic logic [SlotW-1:0] first_set(input logic [NumSlots-1:0] v);
    logic [SlotW-1:0] idx;
    idx = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SlotW'(i);
      end
    end
    return idx;
  endfunction

  assign free_idx    = first_set(free_q);
  assign pick_idx    = first_set(pick_q);
  assign idm_idx     = first_set(idm_q);
  assign next_id_ext = IdExtW'(next_id_q);

  // Scan flags: free slots, runnable slots other than the current one, id matches.
  always_comb begin
    for (int s = 0; s < NumSlots; s++) begin
      free_d[s] = (state_q[s] == SLOT_FREE);
      pick_d[s] = (SlotW'(s) != cur_q) && (state_q[s] == SLOT_RUNNABLE);
      idm_d[s]  = (IdExtW'(id_q[s]) == IdExtW'(req_q.target_tid));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      free_q <= free_d;
      pick_q <= pick_d;
      idm_q  <= idm_d;
    end
  end

  // Table updates on accept and on apply.
  always_comb begin
    state_d   = state_q;
    id_d      = id_q;
    fresh_d   = fresh_q;
    cur_d     = cur_q;
    next_id_d = next_id_q;
    req_d     = req_q;
    stat_d    = stat_q;
    new_tid_d = new_tid_q;
    sw_d      = sw_q;
    fr_d      = fr_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    // Yield and exit first release the caller's slot.
    if (cmd_i.accept) begin
      req_d = in_req_i;
      if (in_req_i.func == FUNC_YIELD) begin
        state_d[cur_q] = SLOT_RUNNABLE;
      end else if (in_req_i.func == FUNC_EXIT) begin
        state_d[cur_q] = SLOT_FREE;
      end
    end

    if (cmd_i.apply) begin
      stat_d    = STAT_IGNORED;
      new_tid_d = '0;
      sw_d      = 1'b0;
      fr_d      = 1'b0;
      case (req_q.func)
        FUNC_CREATE: begin
          if (|free_q) begin
            id_d[free_idx]    = next_id_q;
            fresh_d[free_idx] = 1'b1;
            state_d[free_idx] = SLOT_RUNNABLE;
            ram_we            = 1'b1;
            new_tid_d         = next_id_ext[15:0];
            next_id_d         = next_id_q + 1'b1;
            stat_d            = STAT_DONE;
          end else begin
            stat_d = STAT_FULL;
          end
        end
        FUNC_YIELD, FUNC_EXIT: begin
          if (|pick_q) begin
            state_d[pick_idx] = SLOT_RUNNING;
            fresh_d[pick_idx] = 1'b0;
            fr_d              = fresh_q[pick_idx];
            sw_d              = 1'b1;
            cur_d             = pick_idx;
            ram_re            = 1'b1;
            stat_d            = STAT_DONE;
          end else if (state_q[cur_q] == SLOT_RUNNABLE) begin
            stat_d = STAT_DONE;
          end else begin
            stat_d = STAT_NORUN;
          end
        end
        FUNC_SUSPEND: begin
          if ((|idm_q) && (state_q[idm_idx] == SLOT_RUNNABLE ||
                           state_q[idm_idx] == SLOT_RUNNING)) begin
            state_d[idm_idx] = SLOT_WAIT;
            stat_d           = STAT_DONE;
          end
        end
        FUNC_RESUME: begin
          if ((|idm_q) && (state_q[idm_idx] == SLOT_WAIT)) begin
            state_d[idm_idx] = SLOT_RUNNABLE;
            stat_d           = STAT_DONE;
          end
        end
        default: stat_d = STAT_IGNORED;
      endcase
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumSlots; s++) begin
        state_q[s] <= (s == 0) ? SLOT_RUNNING : SLOT_FREE;
        id_q[s]    <= '0;
      end
      fresh_q   <= '0;
      cur_q     <= '0;
      next_id_q <= IdBits'(1);
    end else begin
      state_q   <= state_d;
      id_q      <= id_d;
      fresh_q   <= fresh_d;
      cur_q     <= cur_d;
      next_id_q <= next_id_d;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    stat_q    <= stat_d;
    new_tid_q <= new_tid_d;
    sw_q      <= sw_d;
    fr_q      <= fr_d;
  end

  cts_ram #(
    .Width(32),
    .Depth(NumSlots)
  ) u_start_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_idx),
    .wdata_i(req_q.entry_address),
    .re_i   (ram_re),
    .raddr_i(pick_idx),
    .rdata_o(ram_rdata)
  );

  assign cur_ext    = SlotExtW'(cur_q);
  assign cur_id_ext = IdExtW'(id_q[cur_q]);

  // Output register; a waiting result does not block a new request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.status        <= stat_q;
      out_q.new_tid       <= new_tid_q;
      out_q.switched      <= sw_q;
      out_q.running_slot  <= cur_ext[3:0];
      out_q.running_tid   <= cur_id_ext[15:0];
      out_q.first_run     <= fr_q;
      out_q.start_address <= sw_q ? ram_rdata : 32'd0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_rsp_o      = out_q;

endmodule

// ===== sim/cooperative_thread_slot_scheduler_test.sv =====
// Self-checking testbench for the cooperative thread slot scheduler.
module cooperative_thread_slot_scheduler_test;
  import cts_pkg::*;

  localparam int NumSlots    = NumSlotsDef;
  localparam int IdSpan      = 1 << IdBitsDef;
  localparam int StallLimit  = 5000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 16;
  localparam int PrintLimit  = 100;
  localparam int ChurnPairs  = 60;

  // Request codes that the block does not know and must ignore.
  localparam logic [2:0] FuncBadLow  = 3'd5;
  localparam logic [2:0] FuncBadHigh = 3'd7;

  logic clk;
  logic rst_n;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // Traffic controls: idle_en on both channels, hold_outputs on the result channel.
  bit idle_en;
  bit hold_outputs;

  // Predicted copy of the slot table.
  slot_state_e sched_state [NumSlots];
  logic [15:0] sched_id [NumSlots];
  logic [31:0] sched_start [NumSlots];
  bit          sched_fresh [NumSlots];
  bit          sched_written [NumSlots];
  logic [3:0]  sched_cur;
  logic [15:0] sched_next_id;

  rsp_t pending_results[$];
  int   error_count;
  int   result_count;
  int   quiet_cycles;

  cooperative_thread_slot_scheduler uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_req_i    (req),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .out_rsp_o   (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_error(input string msg);
    if (error_count < PrintLimit) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             result_count, name, got, want));
    end
  endtask

  // First slot holding the id, or NumSlots when no slot holds it.
  function automatic int slot_with_id(logic [15:0] tid);
    int found;
    found = NumSlots;
    for (int s = NumSlots - 1; s >= 0; s--) begin
      if (sched_id[s] == tid) found = s;
    end
    return found;
  endfunction

  // Scheduling after yield or exit: lowest other runnable slot, else keep current.
  function automatic rsp_t run_schedule(rsp_t o);
    int pick;
    pick = NumSlots;
    for (int s = NumSlots - 1; s >= 0; s--) begin
      if (s != sched_cur && sched_state[s] == SLOT_RUNNABLE) pick = s;
    end
    if (pick < NumSlots) begin
      sched_state[pick] = SLOT_RUNNING;
      o.switched        = 1'b1;
      o.first_run       = sched_fresh[pick];
      o.start_address   = sched_start[pick];
      sched_fresh[pick] = 1'b0;
      sched_cur         = pick[3:0];
      o.status          = STAT_DONE;
    end else if (sched_state[sched_cur] == SLOT_RUNNABLE) begin
      o.status = STAT_DONE;
    end else begin
      o.status = STAT_NORUN;
    end
    return o;
  endfunction

  // Updates the predicted table for one request and returns its result.
  function automatic rsp_t predict_result(req_t r);
    rsp_t o;
    int   s;
    o        = '0;
    o.status = STAT_IGNORED;
    case (r.func)
      FUNC_CREATE: begin
        o.status = STAT_FULL;
        s = NumSlots;
        for (int k = NumSlots - 1; k >= 0; k--) begin
          if (sched_state[k] == SLOT_FREE) s = k;
        end
        if (s < NumSlots) begin
          sched_id[s]      = sched_next_id;
          sched_start[s]   = r.entry_address;
          sched_fresh[s]   = 1'b1;
          sched_written[s] = 1'b1;
          sched_state[s]   = SLOT_RUNNABLE;
          o.new_tid        = sched_next_id;
          sched_next_id    = sched_next_id + 16'd1;
          o.status         = STAT_DONE;
        end
      end
      FUNC_YIELD: begin
        sched_state[sched_cur] = SLOT_RUNNABLE;
        o = run_schedule(o);
      end
      FUNC_EXIT: begin
        sched_state[sched_cur] = SLOT_FREE;
        o = run_schedule(o);
      end
      FUNC_SUSPEND: begin
        s = slot_with_id(r.target_tid);
        if (s < NumSlots &&
            (sched_state[s] == SLOT_RUNNABLE || sched_state[s] == SLOT_RUNNING)) begin
          sched_state[s] = SLOT_WAIT;
          o.status       = STAT_DONE;
        end
      end
      FUNC_RESUME: begin
        s = slot_with_id(r.target_tid);
        if (s < NumSlots && sched_state[s] == SLOT_WAIT) begin
          sched_state[s] = SLOT_RUNNABLE;
          o.status       = STAT_DONE;
        end
      end
      default: begin
      end
    endcase
    o.running_slot = sched_cur;
    o.running_tid  = sched_id[sched_cur];
    return o;
  endfunction

  // A slot whose start address was never stored must never become runnable.
  function automatic bit req_is_safe(req_t r);
    int s;
    s = slot_with_id(r.target_tid);
    if (r.func == FUNC_YIELD) return sched_written[sched_cur];
    if (r.func == FUNC_RESUME && s < NumSlots) begin
      return sched_written[s] || sched_state[s] != SLOT_WAIT;
    end
    return 1'b1;
  endfunction

  function automatic req_t mk_req(logic [2:0] f, logic [15:0] tid, logic [31:0] addr);
    req_t r;
    r.func          = f;
    r.target_tid    = tid;
    r.entry_address = addr;
    return r;
  endfunction

  // Random request, mostly aimed at ids that live in the table.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    do begin
      pick = $urandom_range(0, 19);
      case ($urandom_range(0, 9))
        0, 1:    r.target_tid = 16'($urandom_range(0, IdSpan - 1));
        2:       r.target_tid = sched_id[sched_cur];
        default: r.target_tid = sched_id[$urandom_range(0, NumSlots - 1)];
      endcase
      r.entry_address = $urandom();
      if (pick < 4) r.func = FUNC_CREATE;
      else if (pick < 9) r.func = FUNC_YIELD;
      else if (pick < 13) r.func = FUNC_EXIT;
      else if (pick < 16) r.func = FUNC_SUSPEND;
      else if (pick < 19) r.func = FUNC_RESUME;
      else r.func = 3'($urandom_range(FuncBadLow, FuncBadHigh));
    end while (!req_is_safe(r));
    return r;
  endfunction

  // Offers one request transaction and records its prediction once accepted.
  task automatic send_req(input req_t r, output rsp_t want);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    want = predict_result(r);
    pending_results.push_back(want);
  endtask

  task automatic test_ignored_requests();
    rsp_t want;
    send_req(mk_req(FUNC_RESUME, 16'h0000, 32'h0000_0000), want);
    send_req(mk_req(FUNC_SUSPEND, 16'hFFFF, 32'hFFFF_FFFF), want);
    send_req(mk_req(FuncBadHigh, 16'hFFFF, 32'hFFFF_FFFF), want);
  endtask

  task automatic test_exit_nothing_runnable();
    rsp_t want;
    send_req(mk_req(FUNC_EXIT, 16'h0000, 32'h0000_0000), want);
  endtask

  task automatic test_create_and_switch();
    rsp_t want;
    send_req(mk_req(FUNC_CREATE, 16'h0000, 32'h0000_0000), want);
    send_req(mk_req(FUNC_CREATE, 16'hFFFF, 32'hFFFF_FFFF), want);
    send_req(mk_req(FUNC_YIELD, 16'h0000, 32'h0000_0000), want);
    send_req(mk_req(FUNC_YIELD, 16'h0000, 32'h0000_0000), want);
  endtask

  // Waiting slots are skipped, the lone runnable caller is kept, and
  // suspending the caller does not schedule.
  task automatic test_suspend_resume();
    rsp_t want;
    send_req(mk_req(FUNC_SUSPEND, 16'd2, 32'h0000_0000), want);
    send_req(mk_req(FUNC_YIELD, 16'h0000, 32'h0000_0000), want);
    send_req(mk_req(FUNC_RESUME, 16'd2, 32'h0000_0000), want);
    send_req(mk_req(FUNC_RESUME, 16'd2, 32'h0000_0000), want);
    send_req(mk_req(FUNC_SUSPEND, 16'd1, 32'h0000_0000), want);
    send_req(mk_req(FUNC_YIELD, 16'h0000, 32'h0000_0000), want);
  endtask

  task automatic test_table_full();
    rsp_t want;
    do begin
      send_req(mk_req(FUNC_CREATE, 16'($urandom_range(0, IdSpan - 1)), $urandom()), want);
    end while (want.status != STAT_FULL);
  endtask

  // The receiver stops for a long stretch while requests keep coming.
  task automatic test_backpressure();
    rsp_t want;
    hold_outputs = 1'b1;
    repeat (24) send_req(random_request(), want);
  endtask

  task automatic test_random_traffic(input int items, input bit with_idle);
    rsp_t want;
    int   sent;
    sent = 0;
    while (sent < items) begin
      if (sent % 64 == 0) idle_en = with_idle && ($urandom_range(0, 2) != 0);
      send_req(random_request(), want);
      sent++;
    end
  endtask

  // Each exit frees the running slot, so the create after it always succeeds.
  task automatic test_exit_create_churn();
    rsp_t want;
    idle_en = 1'b0;
    repeat (ChurnPairs) begin
      send_req(mk_req(FUNC_EXIT, 16'($urandom_range(0, IdSpan - 1)), $urandom()), want);
      send_req(mk_req(FUNC_CREATE, 16'($urandom_range(0, IdSpan - 1)), $urandom()), want);
    end
  endtask

  task automatic finish_run();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  endtask

  // Receiver: random stalls, plus one long hold on request.
  initial begin
    forever begin
      if (hold_outputs) begin
        rsp_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_outputs = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare every result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (rst_n && rsp_valid && rsp_ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_error($sformatf("result %0d arrived with no request outstanding",
                               result_count));
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(rsp.status), 32'(want.status));
        check_field("new_tid", 32'(rsp.new_tid), 32'(want.new_tid));
        check_field("switched", 32'(rsp.switched), 32'(want.switched));
        check_field("running_slot", 32'(rsp.running_slot), 32'(want.running_slot));
        check_field("running_tid", 32'(rsp.running_tid), 32'(want.running_tid));
        check_field("first_run", 32'(rsp.first_run), 32'(want.first_run));
        check_field("start_address", rsp.start_address, want.start_address);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Timeout: no transaction for %0d cycles", StallLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_n        <= 1'b0;
    req_valid    <= 1'b0;
    req          <= '0;
    idle_en      = 1'b1;
    hold_outputs = 1'b0;
    error_count  = 0;
    result_count = 0;
    quiet_cycles = 0;
    for (int s = 0; s < NumSlots; s++) begin
      sched_state[s]   = SLOT_FREE;
      sched_id[s]      = '0;
      sched_start[s]   = '0;
      sched_fresh[s]   = 1'b0;
      sched_written[s] = 1'b0;
    end
    sched_state[0] = SLOT_RUNNING;
    sched_cur      = '0;
    sched_next_id  = 16'd1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ignored_requests();
    test_exit_nothing_runnable();
    test_create_and_switch();
    test_suspend_resume();
    test_table_full();
    test_backpressure();
    test_random_traffic(950, 1'b1);
    test_exit_create_churn();
    test_random_traffic(200, 1'b0);
    finish_run();
  end

endmodule
